[sv/grm_pkg.sv]
`timescale 1ns / 1ps
// grm_pkg: shared types, field widths and defaults for the grid ray marcher
// used by grm_front, grm_queue, grm_back and grid_ray_march; no dependencies
package grm_pkg;

  // default structure sizes
  localparam int MAP_SIDE_DEF      = 64;
  localparam int CELL_BITS_DEF     = 8;
  localparam int ANGLE_STEPS_DEF   = 4096;
  localparam int FRACTION_BITS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // port field widths
  localparam int IDX_W    = 12;
  localparam int VAL_W    = 8;
  localparam int PIN_W    = 16;
  localparam int ANG_W    = 12;
  localparam int STATUS_W = 2;
  localparam int DIST_W   = 22;
  localparam int HIT_W    = 18;
  localparam int CTYPE_W  = 8;

  // configuration register widths
  localparam int MAPDIM_W   = 7;
  localparam int STEP_W     = 10;
  localparam int MAXS_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // configuration reset values
  localparam logic [MAPDIM_W-1:0] MAP_WIDTH_RST  = 7'd64;
  localparam logic [MAPDIM_W-1:0] MAP_HEIGHT_RST = 7'd64;
  localparam logic [STEP_W-1:0]   STEP_SIZE_RST  = 10'd51;
  localparam logic [MAXS_W-1:0]   MAX_STEPS_RST  = 12'd400;

  // q30 constants for the sine series
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_STEP_SIZE  = 2'd2,
    CFG_MAX_STEPS  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_DROP  = 2'd1,
    OP_CAST  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_LEFT  = 2'd2,
    ST_WRITE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_SIN,
    BS_COS,
    BS_MULC,
    BS_START,
    BS_STEP,
    BS_PROBE,
    BS_TEST,
    BS_DONE
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] cell_index;
    logic [VAL_W-1:0] cell_value;
    logic [PIN_W-1:0] pos_x;
    logic [PIN_W-1:0] pos_y;
    logic [ANG_W-1:0] angle;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_req_t;

  typedef struct packed {
    logic [MAPDIM_W-1:0] map_width;
    logic [MAPDIM_W-1:0] map_height;
    logic [STEP_W-1:0]   step_size;
    logic [MAXS_W-1:0]   max_steps;
  } cfg_t;

endpackage

[sv/grm_front.sv]
`timescale 1ns / 1ps
// grm_front: takes input requests, classifies them and folds the angle into one turn
// depends on grm_pkg; feeds grm_queue
module grm_front #(
  parameter int MAP_SIDE    = grm_pkg::MAP_SIDE_DEF,
  parameter int ANGLE_STEPS = grm_pkg::ANGLE_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [grm_pkg::IDX_W-1:0] cell_index_i,
  input  logic [grm_pkg::VAL_W-1:0] cell_value_i,
  input  logic [grm_pkg::PIN_W-1:0] pos_x_i,
  input  logic [grm_pkg::PIN_W-1:0] pos_y_i,
  input  logic [grm_pkg::ANG_W-1:0] angle_i,
  input  logic                      busy_i,
  input  logic                      q_full_i,
  output grm_pkg::item_req_t        push_o
);
  import grm_pkg::*;

  localparam int TURN        = (ANGLE_STEPS / 4) * 4;
  localparam int STORE_DEPTH = MAP_SIDE * MAP_SIDE;

  item_t hold_q, hold_d, fresh;
  logic  hold_vld_q, hold_vld_d;
  logic  accept, wrap, push;

  assign in_stall_o = hold_vld_q || busy_i;
  assign accept     = in_valid_i && !in_stall_o;

  // classify the incoming request
  always_comb begin
    fresh.cell_index = cell_index_i;
    fresh.cell_value = cell_value_i;
    fresh.pos_x      = pos_x_i;
    fresh.pos_y      = pos_y_i;
    fresh.angle      = angle_i;
    if (action_i) begin
      fresh.op = OP_CAST;
    end else if (32'(cell_index_i) < 32'(STORE_DEPTH)) begin
      fresh.op = OP_WRITE;
    end else begin
      fresh.op = OP_DROP;
    end
  end

  // one turn subtracted per cycle until the angle is below a full turn
  assign wrap = (hold_q.op == OP_CAST) && (32'(hold_q.angle) >= 32'(TURN));
  assign push = hold_vld_q && !wrap && !q_full_i;

  always_comb begin
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    if (accept) begin
      hold_d     = fresh;
      hold_vld_d = 1'b1;
    end else if (hold_vld_q && wrap) begin
      hold_d.angle = hold_q.angle - ANG_W'(TURN);
    end else if (push) begin
      hold_vld_d = 1'b0;
    end
  end

  assign push_o.valid = push;
  assign push_o.item  = hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

[sv/grm_queue.sv]
`timescale 1ns / 1ps
// grm_queue: short fifo of classified requests between front and back
// depends on grm_pkg
module grm_queue #(
  parameter int DEPTH = grm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grm_pkg::item_req_t push_i,
  input  logic               pop_i,
  output grm_pkg::item_req_t head_o,
  output logic               full_o
);
  import grm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = entries[rd_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_q] <= push_i.item;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from an empty queue");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[sv/grm_back.sv]
`timescale 1ns / 1ps
// grm_back: map store, quarter-wave sine rom and the ray stepping sequencer
// depends on grm_pkg; takes requests from grm_queue and drives the result register
module grm_back #(
  parameter int MAP_SIDE      = grm_pkg::MAP_SIDE_DEF,
  parameter int CELL_BITS     = grm_pkg::CELL_BITS_DEF,
  parameter int ANGLE_STEPS   = grm_pkg::ANGLE_STEPS_DEF,
  parameter int FRACTION_BITS = grm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grm_pkg::cfg_t                       cfg_i,
  input  grm_pkg::item_req_t                  head_i,
  output logic                                pop_o,
  output logic                                busy_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [grm_pkg::STATUS_W-1:0]        status_o,
  output logic [grm_pkg::DIST_W-1:0]          distance_o,
  output logic signed [grm_pkg::HIT_W-1:0]    hit_x_o,
  output logic signed [grm_pkg::HIT_W-1:0]    hit_y_o,
  output logic [grm_pkg::CTYPE_W-1:0]         cell_type_o
);
  import grm_pkg::*;

  localparam int QUARTER     = ANGLE_STEPS / 4;
  localparam int TURN        = QUARTER * 4;
  localparam int QB          = $clog2(QUARTER);
  localparam int AW          = $clog2(TURN) + 2;
  localparam int SB          = $clog2(MAP_SIDE);
  localparam int WB          = $clog2(MAP_SIDE + 1);
  localparam int STORE_DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SPAN        = (FRACTION_BITS + SB + 1 > 17) ? FRACTION_BITS + SB + 1 : 17;
  localparam int POS_W       = SPAN + 2;
  localparam int HI_W        = POS_W - 1 - FRACTION_BITS;
  localparam int MAG_W       = 17;
  localparam int PROD_W      = STEP_W + MAG_W;
  localparam int SERIES_N    = 12;

  typedef logic [15:0] rom_t [QUARTER];

  typedef struct packed {
    logic          neg;
    logic          one;
    logic [QB-1:0] idx;
  } fold_t;

  // floor(65536*sin) by the alternating series in q30, worked out at elaboration
  function automatic logic [15:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] val;
    logic        minus;
    x     = (64'(k) * 64'd2 * PI_Q30) / 64'(ANGLE_STEPS);
    x2    = (x * x) >> 30;
    term  = x;
    pos   = '0;
    neg   = '0;
    minus = 1'b0;
    for (int i = 0; i < SERIES_N; i++) begin
      if (term != '0) begin
        if (minus) neg = neg + term;
        else       pos = pos + term;
        term = (term * x2) >> 30;
        unique case (i)
          0:       term = term / 64'd6;
          1:       term = term / 64'd20;
          2:       term = term / 64'd42;
          3:       term = term / 64'd72;
          4:       term = term / 64'd110;
          5:       term = term / 64'd156;
          6:       term = term / 64'd210;
          7:       term = term / 64'd272;
          8:       term = term / 64'd342;
          9:       term = term / 64'd420;
          10:      term = term / 64'd506;
          default: term = term / 64'd600;
        endcase
        minus = !minus;
      end
    end
    val = (pos > neg) ? (pos - neg) : '0;
    if (val >= ONE_Q30) val = ONE_Q30 - 64'd1;
    return val[29:14];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < QUARTER; k++) begin
      r[k] = sine_entry(k);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // quadrant folding onto the quarter-wave table
  function automatic fold_t fold(input logic [AW-1:0] a);
    fold_t         f;
    logic [AW-1:0] k;
    priority if (a < AW'(QUARTER)) begin
      k     = a;
      f.neg = 1'b0;
    end else if (a < AW'(2 * QUARTER)) begin
      k     = AW'(2 * QUARTER) - a;
      f.neg = 1'b0;
    end else if (a < AW'(3 * QUARTER)) begin
      k     = a - AW'(2 * QUARTER);
      f.neg = 1'b1;
    end else begin
      k     = AW'(4 * QUARTER) - a;
      f.neg = 1'b1;
    end
    f.one = (k >= AW'(QUARTER));
    f.idx = f.one ? '0 : QB'(k);
    return f;
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input fold_t f, input logic [15:0] r);
    return f.one ? MAG_W'(65536) : MAG_W'(r);
  endfunction

  // rounded per-step delta with the sign applied
  function automatic logic [POS_W-1:0] delta(input logic [PROD_W-1:0] p, input logic neg);
    logic [PROD_W:0]  s;
    logic [POS_W-1:0] d;
    s = {1'b0, p} + (PROD_W + 1)'(32768);
    d = POS_W'(s[PROD_W:16]);
    return neg ? -d : d;
  endfunction

  back_state_e             state_q, state_d;
  logic [ADDR_W-1:0]       clr_q, clr_d;
  logic [AW-1:0]           a_q, a_d, cos_sum, cos_a;
  fold_t                   sin_fold, cos_fold, sin_f_q, sin_f_d, cos_f_q, cos_f_d;
  logic [15:0]             rom_q;
  logic [QB-1:0]           rom_addr;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [POS_W-1:0]        dx_q, dx_d, dy_q, dy_d, x_q, x_d, y_q, y_d;
  logic [DIST_W-1:0]       dist_q, dist_d;
  logic [MAXS_W-1:0]       steps_q, steps_d;
  logic [CELL_BITS-1:0]    cell_q, cell_d, mem_q, mem_wdata;
  status_e                 res_q, res_d;
  logic [CELL_BITS-1:0]    map_mem [STORE_DEPTH];
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [WB-1:0]           w_eff, h_eff;
  logic [HI_W-1:0]         col_hi, row_hi;
  logic [SB-1:0]           col, row;
  logic                    outside, cell_hit, at_max, load_out, clr_last;
  logic                    out_vld_q, out_vld_d;
  status_e                 out_status_q;
  logic [DIST_W-1:0]       out_dist_q;
  logic [HIT_W-1:0]        out_x_q, out_y_q;
  logic [CELL_BITS-1:0]    out_cell_q;

  // shared decode
  assign w_eff = (32'(cfg_i.map_width) < 32'(MAP_SIDE)) ? WB'(cfg_i.map_width) : WB'(MAP_SIDE);
  assign h_eff = (32'(cfg_i.map_height) < 32'(MAP_SIDE)) ? WB'(cfg_i.map_height)
                                                         : WB'(MAP_SIDE);
  assign col_hi    = x_q[POS_W-2:FRACTION_BITS];
  assign row_hi    = y_q[POS_W-2:FRACTION_BITS];
  assign col       = x_q[FRACTION_BITS +: SB];
  assign row       = y_q[FRACTION_BITS +: SB];
  assign outside   = x_q[POS_W-1] || y_q[POS_W-1] ||
                     (col_hi >= HI_W'(w_eff)) || (row_hi >= HI_W'(h_eff));
  assign mem_raddr = ADDR_W'(ADDR_W'(row) * ADDR_W'(w_eff)) + ADDR_W'(col);
  assign cell_hit  = (mem_q != '0);
  assign at_max    = (steps_q == cfg_i.max_steps);
  assign load_out  = !out_vld_q || !out_stall_i;
  assign clr_last  = (clr_q == ADDR_W'(STORE_DEPTH - 1));
  assign sin_fold  = fold(a_q);
  assign cos_sum   = a_q + AW'(QUARTER);
  assign cos_a     = (cos_sum >= AW'(TURN)) ? cos_sum - AW'(TURN) : cos_sum;
  assign cos_fold  = fold(cos_a);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_CLEAR: if (clr_last) state_d = BS_IDLE;
      BS_IDLE: begin
        if (head_i.valid) begin
          state_d = (head_i.item.op == OP_CAST) ? BS_SIN : BS_DONE;
        end
      end
      BS_SIN:   state_d = BS_COS;
      BS_COS:   state_d = BS_MULC;
      BS_MULC:  state_d = BS_START;
      BS_START: state_d = (cfg_i.max_steps == '0) ? BS_DONE : BS_STEP;
      BS_STEP:  state_d = BS_PROBE;
      BS_PROBE: state_d = outside ? BS_DONE : BS_TEST;
      BS_TEST:  state_d = (cell_hit || at_max) ? BS_DONE : BS_PROBE;
      BS_DONE:  if (load_out) state_d = BS_IDLE;
      default:  state_d = BS_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    clr_d     = clr_q;
    a_d       = a_q;
    sin_f_d   = sin_f_q;
    cos_f_d   = cos_f_q;
    prod_d    = prod_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    x_d       = x_q;
    y_d       = y_q;
    dist_d    = dist_q;
    steps_d   = steps_q;
    cell_d    = cell_q;
    res_d     = res_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    rom_addr  = sin_fold.idx;
    unique case (state_q)
      BS_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
      end
      BS_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          x_d     = POS_W'(head_i.item.pos_x);
          y_d     = POS_W'(head_i.item.pos_y);
          a_d     = AW'(head_i.item.angle);
          dist_d  = '0;
          steps_d = '0;
          cell_d  = '0;
          res_d   = ST_MISS;
          if (head_i.item.op != OP_CAST) begin
            x_d   = '0;
            y_d   = '0;
            res_d = ST_WRITE;
          end
          if (head_i.item.op == OP_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(head_i.item.cell_index);
            mem_wdata = CELL_BITS'(head_i.item.cell_value);
          end
        end
      end
      BS_SIN: begin
        rom_addr = sin_fold.idx;
        sin_f_d  = sin_fold;
      end
      BS_COS: begin
        rom_addr = cos_fold.idx;
        cos_f_d  = cos_fold;
        prod_d   = PROD_W'(cfg_i.step_size) * PROD_W'(magnitude(sin_f_q, rom_q));
      end
      BS_MULC: begin
        dx_d   = delta(prod_q, sin_f_q.neg);
        prod_d = PROD_W'(cfg_i.step_size) * PROD_W'(magnitude(cos_f_q, rom_q));
      end
      BS_START: begin
        dy_d = delta(prod_q, cos_f_q.neg);
      end
      BS_STEP: begin
        x_d     = x_q + dx_q;
        y_d     = y_q + dy_q;
        dist_d  = dist_q + DIST_W'(cfg_i.step_size);
        steps_d = steps_q + 1'b1;
      end
      BS_PROBE: begin
        if (outside) begin
          res_d = ST_LEFT;
        end
      end
      BS_TEST: begin
        priority if (cell_hit) begin
          res_d  = ST_HIT;
          cell_d = mem_q;
        end else if (at_max) begin
          res_d = ST_MISS;
        end else begin
          x_d     = x_q + dx_q;
          y_d     = y_q + dy_q;
          dist_d  = dist_q + DIST_W'(cfg_i.step_size);
          steps_d = steps_q + 1'b1;
        end
      end
      BS_DONE: begin
        clr_d = clr_q;
      end
      default: begin
        clr_d = clr_q;
      end
    endcase
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (state_q == BS_DONE && load_out) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    sin_f_q <= sin_f_d;
    cos_f_q <= cos_f_d;
    prod_q  <= prod_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    x_q     <= x_d;
    y_q     <= y_d;
    dist_q  <= dist_d;
    steps_q <= steps_d;
    cell_q  <= cell_d;
    res_q   <= res_d;
    if (state_q == BS_DONE && load_out) begin
      out_status_q <= res_q;
      out_dist_q   <= dist_q;
      out_x_q      <= x_q[HIT_W-1:0];
      out_y_q      <= y_q[HIT_W-1:0];
      out_cell_q   <= cell_q;
    end
  end

  // map store and sine rom, registered reads
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  assign busy_o      = (state_q == BS_CLEAR);
  assign out_valid_o = out_vld_q;
  assign status_o    = out_status_q;
  assign distance_o  = out_dist_q;
  assign hit_x_o     = $signed(out_x_q);
  assign hit_y_o     = $signed(out_y_q);
  assign cell_type_o = CTYPE_W'(out_cell_q);

  a_clear_no_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_CLEAR) |-> !pop_o)
    else $error("request taken during the clearing pass");

  a_steps_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_PROBE || state_q == BS_TEST) |->
      (steps_q != '0 && steps_q <= cfg_i.max_steps))
    else $error("step count outside one to max_steps while marching");

  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_DONE && !out_vld_q) |=> (out_vld_q && state_q == BS_IDLE))
    else $error("finished ray not moved to the result register");

  a_write_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == ST_WRITE) |-> (out_dist_q == '0 && out_cell_q == '0))
    else $error("write result carries ray data");

endmodule

[sv/grid_ray_march.sv]
`timescale 1ns / 1ps
// grid_ray_march: top level of the grid map store and fixed-step ray marcher
// depends on grm_pkg, grm_front, grm_queue and grm_back
//
// The block holds a MAP_SIDE x MAP_SIDE map of cell types and answers two kinds of
// request, each with exactly one result. A write request (action 0) stores one cell
// and returns status 3 with all other fields zero; an index beyond the store is
// dropped but still answered. A cast request (action 1) starts a ray at (pos_x, pos_y),
// fixed point with FRACTION_BITS fraction bits, at angle/ANGLE_STEPS of a turn, and
// steps it by step_size*sin in x and step_size*cos in y until it lands on a nonzero
// cell (status 0, cell_type set), leaves the map (status 2) or has taken max_steps
// steps (status 1). After reset the map is cleared one cell per clock with in_stall_o
// high; configuration writes are taken throughout. The front holds one request at a
// time and wraps full turns off the angle when ANGLE_STEPS is below 4096, a queue of
// QUEUE_DEPTH entries (two by default) decouples it from the back end, a write then
// goes straight from idle to done in the back end, and a cast runs a setup of two sine
// rom reads and two 10x17 multiplies and then steps, each step waiting on the
// registered map read. The next request is accepted while a result waits in the
// output register. Configure only while the block is idle.
module grid_ray_march #(
  parameter int MAP_SIDE      = grm_pkg::MAP_SIDE_DEF,
  parameter int CELL_BITS     = grm_pkg::CELL_BITS_DEF,
  parameter int ANGLE_STEPS   = grm_pkg::ANGLE_STEPS_DEF,
  parameter int FRACTION_BITS = grm_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH   = grm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [grm_pkg::IDX_W-1:0]           cell_index_i,
  input  logic [grm_pkg::VAL_W-1:0]           cell_value_i,
  input  logic [grm_pkg::PIN_W-1:0]           pos_x_i,
  input  logic [grm_pkg::PIN_W-1:0]           pos_y_i,
  input  logic [grm_pkg::ANG_W-1:0]           angle_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [grm_pkg::STATUS_W-1:0]        status_o,
  output logic [grm_pkg::DIST_W-1:0]          distance_o,
  output logic signed [grm_pkg::HIT_W-1:0]    hit_x_o,
  output logic signed [grm_pkg::HIT_W-1:0]    hit_y_o,
  output logic [grm_pkg::CTYPE_W-1:0]         cell_type_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [grm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [grm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import grm_pkg::*;

  cfg_t      cfg_q, cfg_d;
  item_req_t push, head;
  logic      q_full, pop, busy;

  // configuration registers, written by index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MAP_WIDTH:  cfg_d.map_width  = cfg_wdata_i[MAPDIM_W-1:0];
        CFG_MAP_HEIGHT: cfg_d.map_height = cfg_wdata_i[MAPDIM_W-1:0];
        CFG_STEP_SIZE:  cfg_d.step_size  = cfg_wdata_i[STEP_W-1:0];
        CFG_MAX_STEPS:  cfg_d.max_steps  = cfg_wdata_i[MAXS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width  <= MAP_WIDTH_RST;
      cfg_q.map_height <= MAP_HEIGHT_RST;
      cfg_q.step_size  <= STEP_SIZE_RST;
      cfg_q.max_steps  <= MAX_STEPS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: takes the request, classifies it and wraps the angle
  grm_front #(
    .MAP_SIDE    (MAP_SIDE),
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .cell_index_i (cell_index_i),
    .cell_value_i (cell_value_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .angle_i      (angle_i),
    .busy_i       (busy),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  // decoupling queue between front and back
  grm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (q_full)
  );

  // back: map store, sine rom, stepping sequencer and result register
  grm_back #(
    .MAP_SIDE      (MAP_SIDE),
    .CELL_BITS     (CELL_BITS),
    .ANGLE_STEPS   (ANGLE_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .distance_o  (distance_o),
    .hit_x_o     (hit_x_o),
    .hit_y_o     (hit_y_o),
    .cell_type_o (cell_type_o)
  );

endmodule
